// ===== design/lkv_pkg.sv =====
// Shared types and constants for the LRU key-value cache.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package lkv_pkg;
    localparam int ENTRIES = 16;
    localparam int IDX_W   = 4;
    localparam int CNT_W   = 5;
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 32;
    localparam int CMD_W   = 3;

    localparam logic [CMD_W-1:0] CMD_GET      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUT      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CONTAINS = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_RSTSTAT  = 3'd5;

    typedef struct packed {
        logic             is_get;
        logic             is_put;
        logic             is_remove;
        logic             is_contains;
        logic             is_clear;
        logic             is_rststat;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } cmd_item_t;
endpackage

// ===== design/lkv_front.sv =====
// Front end: accepts commands, decodes them and holds them in a two-deep queue.
// Depends on lkv_pkg.
`timescale 1ns / 1ps
module lkv_front
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [lkv_pkg::CMD_W-1:0] command,
    input  logic [lkv_pkg::KEY_W-1:0] lookup_key,
    input  logic [lkv_pkg::VAL_W-1:0] store_value,
    output logic                     q_valid,
    output lkv_pkg::cmd_item_t       q_item,
    input  logic                     q_pop
);
    lkv_pkg::cmd_item_t slot_reg [2];
    logic               rd_ptr_reg;
    logic               wr_ptr_reg;
    logic [1:0]         count_reg;
    logic [1:0]         count_next;
    logic               push;
    logic               pop;
    lkv_pkg::cmd_item_t dec;

    always_comb
    begin
        dec             = '0;
        dec.key         = lookup_key;
        dec.value       = store_value;
        dec.is_get      = (command == lkv_pkg::CMD_GET);
        dec.is_put      = (command == lkv_pkg::CMD_PUT);
        dec.is_remove   = (command == lkv_pkg::CMD_REMOVE);
        dec.is_contains = (command == lkv_pkg::CMD_CONTAINS);
        dec.is_clear    = (command == lkv_pkg::CMD_CLEAR);
        dec.is_rststat  = (command == lkv_pkg::CMD_RSTSTAT);
    end

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end
endmodule

// ===== design/lkv_back.sv =====
// Back end: entry store, key match, recency ranks, statistics and result register.
// Depends on lkv_pkg.
`timescale 1ns / 1ps
module lkv_back
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  lkv_pkg::cmd_item_t         q_item,
    output logic                       q_pop,
    input  logic [lkv_pkg::CNT_W-1:0]  capacity,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       found,
    output logic [lkv_pkg::VAL_W-1:0]  read_value,
    output logic                       is_eviction,
    output logic [lkv_pkg::KEY_W-1:0]  evicted_key,
    output logic                       last_result,
    output logic [lkv_pkg::CNT_W-1:0]  occupancy,
    output logic [lkv_pkg::STAT_W-1:0] get_count,
    output logic [lkv_pkg::STAT_W-1:0] hit_count,
    output logic [lkv_pkg::STAT_W-1:0] miss_count,
    output logic [lkv_pkg::STAT_W-1:0] put_count,
    output logic [lkv_pkg::STAT_W-1:0] eviction_count
);
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_LOOK  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;
    localparam logic [1:0] S_EVICT = 2'd3;

    localparam int N = lkv_pkg::ENTRIES;

    logic [lkv_pkg::KEY_W-1:0]  key_reg   [N];
    logic [lkv_pkg::VAL_W-1:0]  val_reg   [N];
    logic [lkv_pkg::IDX_W-1:0]  rank_reg  [N];
    logic [N-1:0]               valid_reg;
    logic [lkv_pkg::CNT_W-1:0]  total_reg;
    logic [lkv_pkg::CNT_W-1:0]  total_next;
    logic [1:0]                 state_reg;
    lkv_pkg::cmd_item_t         cur_reg;
    logic                       hit_reg;
    logic [lkv_pkg::IDX_W-1:0]  slot_reg;
    logic [lkv_pkg::CNT_W-1:0]  final_occ_reg;
    logic [lkv_pkg::CNT_W-1:0]  left_reg;
    logic                       ins_pending_reg;

    logic [lkv_pkg::STAT_W-1:0] gets_reg, hits_reg, misses_reg, puts_reg, evicts_reg;
    logic [lkv_pkg::STAT_W-1:0] gets_next, hits_next, misses_next, puts_next, evicts_next;

    logic                       out_valid_reg;
    logic                       found_reg;
    logic [lkv_pkg::VAL_W-1:0]  rv_reg;
    logic                       is_ev_reg;
    logic [lkv_pkg::KEY_W-1:0]  ev_key_reg;
    logic                       last_reg;
    logic [lkv_pkg::CNT_W-1:0]  occ_reg;

    logic [N-1:0]               hit_vec;
    logic [lkv_pkg::IDX_W-1:0]  hit_slot;
    logic [N-1:0]               victim;
    logic [lkv_pkg::KEY_W-1:0]  victim_key;
    logic [N-1:0]               ins_oh;
    logic [lkv_pkg::IDX_W-1:0]  slot_rank;
    logic [lkv_pkg::CNT_W-1:0]  cap;
    logic [lkv_pkg::CNT_W-1:0]  nev;
    logic                       out_ok;
    logic                       exec_fire;
    logic                       evict_fire;
    logic                       put_new;
    logic                       do_mru;
    logic                       do_put_hit;
    logic                       do_insert;
    logic                       do_remove;
    logic                       do_clear;
    logic                       emit;
    logic                       emit_found;
    logic [lkv_pkg::VAL_W-1:0]  emit_rv;

    assign out_ok     = !out_valid_reg || !out_stall;
    assign q_pop      = (state_reg == S_IDLE) && !ins_pending_reg;
    assign exec_fire  = (state_reg == S_EXEC) && out_ok;
    assign evict_fire = (state_reg == S_EVICT) && out_ok;
    assign slot_rank  = rank_reg[slot_reg];

    always_comb
    begin
        hit_slot = '0;
        for (int i = 0; i < N; i++)
        begin
            hit_vec[i] = valid_reg[i] && (key_reg[i] == cur_reg.key);
        end
        for (int i = N - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                hit_slot = lkv_pkg::IDX_W'(i);
            end
        end
    end

    // lowest free slot takes the new entry
    always_comb
    begin
        ins_oh     = '0;
        victim_key = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                ins_oh = '0;
                ins_oh[i] = 1'b1;
            end
        end
        for (int i = 0; i < N; i++)
        begin
            victim[i] = valid_reg[i]
                && (rank_reg[i] == lkv_pkg::IDX_W'(total_reg - 5'd1));
            if (victim[i])
            begin
                victim_key = key_reg[i];
            end
        end
    end

    always_comb
    begin
        if (capacity == 5'd0)
        begin
            cap = 5'd1;
        end
        else if (capacity > lkv_pkg::CNT_W'(N))
        begin
            cap = lkv_pkg::CNT_W'(N);
        end
        else
        begin
            cap = capacity;
        end
        nev = (total_reg + 5'd1 > cap) ? (total_reg + 5'd1 - cap) : 5'd0;
    end

    always_comb
    begin
        put_new     = cur_reg.is_put && !hit_reg;
        do_mru      = exec_fire && hit_reg && (cur_reg.is_get || cur_reg.is_put);
        do_put_hit  = exec_fire && hit_reg && cur_reg.is_put;
        do_insert   = (exec_fire && put_new && (nev == 5'd0)) || ins_pending_reg;
        do_remove   = exec_fire && hit_reg && cur_reg.is_remove;
        do_clear    = exec_fire && cur_reg.is_clear;
        emit        = (exec_fire && !(put_new && (nev != 5'd0))) || evict_fire;
        emit_found  = hit_reg && (cur_reg.is_get || cur_reg.is_put
            || cur_reg.is_remove || cur_reg.is_contains);
        emit_rv     = (cur_reg.is_get && hit_reg) ? val_reg[slot_reg] : '0;

        gets_next   = gets_reg;
        hits_next   = hits_reg;
        misses_next = misses_reg;
        puts_next   = puts_reg;
        evicts_next = evicts_reg;
        if (exec_fire)
        begin
            if (cur_reg.is_rststat)
            begin
                gets_next   = '0;
                hits_next   = '0;
                misses_next = '0;
                puts_next   = '0;
                evicts_next = '0;
            end
            if (cur_reg.is_get)
            begin
                gets_next = gets_reg + 32'd1;
                if (hit_reg)
                begin
                    hits_next = hits_reg + 32'd1;
                end
                else
                begin
                    misses_next = misses_reg + 32'd1;
                end
            end
            if (cur_reg.is_put)
            begin
                puts_next = puts_reg + 32'd1;
                if (!hit_reg)
                begin
                    evicts_next = evicts_reg + lkv_pkg::STAT_W'(nev);
                end
            end
        end

        total_next = total_reg;
        if (do_clear)
        begin
            total_next = '0;
        end
        else if (do_remove || evict_fire)
        begin
            total_next = total_reg - 5'd1;
        end
        else if (do_insert)
        begin
            total_next = total_reg + 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < N; i++)
        begin
            if (do_insert && ins_oh[i])
            begin
                key_reg[i]  <= cur_reg.key;
                val_reg[i]  <= cur_reg.value;
                rank_reg[i] <= '0;
            end
            else if (do_insert && valid_reg[i])
            begin
                rank_reg[i] <= rank_reg[i] + 4'd1;
            end
            if (do_put_hit && (slot_reg == lkv_pkg::IDX_W'(i)))
            begin
                val_reg[i] <= cur_reg.value;
            end
            if (do_mru)
            begin
                if (slot_reg == lkv_pkg::IDX_W'(i))
                begin
                    rank_reg[i] <= '0;
                end
                else if (valid_reg[i] && (rank_reg[i] < slot_rank))
                begin
                    rank_reg[i] <= rank_reg[i] + 4'd1;
                end
            end
            if (do_remove && valid_reg[i] && (rank_reg[i] > slot_rank))
            begin
                rank_reg[i] <= rank_reg[i] - 4'd1;
            end
        end
        if (q_pop && q_valid)
        begin
            cur_reg <= q_item;
        end
        if (state_reg == S_LOOK)
        begin
            hit_reg  <= |hit_vec;
            slot_reg <= hit_slot;
        end
        if (exec_fire && put_new)
        begin
            final_occ_reg <= (nev == 5'd0) ? total_reg + 5'd1 : cap;
            left_reg      <= nev;
        end
        else if (evict_fire)
        begin
            left_reg <= left_reg - 5'd1;
        end
        if (emit)
        begin
            if (evict_fire)
            begin
                found_reg  <= 1'b0;
                rv_reg     <= '0;
                is_ev_reg  <= 1'b1;
                ev_key_reg <= victim_key;
                last_reg   <= (left_reg == 5'd1);
                occ_reg    <= final_occ_reg;
            end
            else
            begin
                found_reg  <= emit_found;
                rv_reg     <= emit_rv;
                is_ev_reg  <= 1'b0;
                ev_key_reg <= '0;
                last_reg   <= 1'b1;
                occ_reg    <= total_next;
            end
            get_count      <= gets_next;
            hit_count      <= hits_next;
            miss_count     <= misses_next;
            put_count      <= puts_next;
            eviction_count <= evicts_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            total_reg       <= '0;
            state_reg       <= S_IDLE;
            ins_pending_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            gets_reg        <= '0;
            hits_reg        <= '0;
            misses_reg      <= '0;
            puts_reg        <= '0;
            evicts_reg      <= '0;
        end
        else
        begin
            total_reg  <= total_next;
            gets_reg   <= gets_next;
            hits_reg   <= hits_next;
            misses_reg <= misses_next;
            puts_reg   <= puts_next;
            evicts_reg <= evicts_next;
            for (int i = 0; i < N; i++)
            begin
                if (do_clear)
                begin
                    valid_reg[i] <= 1'b0;
                end
                else if (do_remove && (slot_reg == lkv_pkg::IDX_W'(i)))
                begin
                    valid_reg[i] <= 1'b0;
                end
                else if (evict_fire && victim[i])
                begin
                    valid_reg[i] <= 1'b0;
                end
                else if (do_insert && ins_oh[i])
                begin
                    valid_reg[i] <= 1'b1;
                end
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            ins_pending_reg <= evict_fire && (left_reg == 5'd1);
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_pop && q_valid)
                    begin
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    if (exec_fire)
                    begin
                        state_reg <= (put_new && (nev != 5'd0)) ? S_EVICT : S_IDLE;
                    end
                end
                S_EVICT:
                begin
                    // hand the insert of the new key to the cycle after the last eviction
                    if (evict_fire && (left_reg == 5'd1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign read_value  = rv_reg;
    assign is_eviction = is_ev_reg;
    assign evicted_key = ev_key_reg;
    assign last_result = last_reg;
    assign occupancy   = occ_reg;

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= lkv_pkg::CNT_W'(N))
        else $error("entry total above entry count");

    a_total_match: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(total_reg))
        else $error("entry total disagrees with valid bits");

    a_one_victim: assert property (@(posedge clk) disable iff (!rst_n)
        evict_fire |-> $onehot(victim))
        else $error("eviction without a single least recent entry");

    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        do_insert |-> (ins_oh != '0))
        else $error("insert with no free slot");
endmodule

// ===== design/lru_key_value_cache.sv =====
// Top level of the LRU key-value cache: capacity register, front queue, back end.
// Depends on lkv_pkg, lkv_front and lkv_back.
`timescale 1ns / 1ps
// A command passes through the back end in steps: it is taken from the two-deep
// input queue, its key is matched against all sixteen entries, and then the command
// is applied and the result register loaded. A stalled result register holds the
// back end in its apply step until the result leaves. A put of a new key that must
// evict gives one result per evicted entry, each in its own evict step, and then
// inserts the new key. Results wait in a single output register; the input queue keeps
// accepting while it has room. Writes to capacity take effect on the next put of a
// new key; nothing is trimmed at the write.
module lru_key_value_cache
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [lkv_pkg::CMD_W-1:0]  command,
    input  logic [lkv_pkg::KEY_W-1:0]  lookup_key,
    input  logic [lkv_pkg::VAL_W-1:0]  store_value,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       found,
    output logic [lkv_pkg::VAL_W-1:0]  read_value,
    output logic                       is_eviction,
    output logic [lkv_pkg::KEY_W-1:0]  evicted_key,
    output logic                       last_result,
    output logic [lkv_pkg::CNT_W-1:0]  occupancy,
    output logic [lkv_pkg::STAT_W-1:0] get_count,
    output logic [lkv_pkg::STAT_W-1:0] hit_count,
    output logic [lkv_pkg::STAT_W-1:0] miss_count,
    output logic [lkv_pkg::STAT_W-1:0] put_count,
    output logic [lkv_pkg::STAT_W-1:0] eviction_count,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [lkv_pkg::CNT_W-1:0]  cfg_data
);
    logic [lkv_pkg::CNT_W-1:0] capacity_reg;
    logic                      q_valid;
    logic                      q_pop;
    lkv_pkg::cmd_item_t        q_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= lkv_pkg::CNT_W'(lkv_pkg::ENTRIES);
        end
        else if (cfg_valid && cfg_ready)
        begin
            capacity_reg <= cfg_data;
        end
    end

    lkv_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .lookup_key  (lookup_key),
        .store_value (store_value),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    lkv_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .capacity       (capacity_reg),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .found          (found),
        .read_value     (read_value),
        .is_eviction    (is_eviction),
        .evicted_key    (evicted_key),
        .last_result    (last_result),
        .occupancy      (occupancy),
        .get_count      (get_count),
        .hit_count      (hit_count),
        .miss_count     (miss_count),
        .put_count      (put_count),
        .eviction_count (eviction_count)
    );
endmodule

// ===== tb/lru_key_value_cache_tb.sv =====
// Testbench for the LRU key-value cache: directed and random commands, capacity changes.
// Predicts every result with its own LRU store model; depends on lkv_pkg and the block.
`timescale 1ns / 1ps
module lru_key_value_cache_tb;
    localparam logic [lkv_pkg::CMD_W-1:0] CMD_SPARE6 = 3'd6;
    localparam logic [lkv_pkg::CMD_W-1:0] CMD_SPARE7 = 3'd7;

    typedef struct packed {
        logic                       found;
        logic [lkv_pkg::VAL_W-1:0]  read_value;
        logic                       is_eviction;
        logic [lkv_pkg::KEY_W-1:0]  evicted_key;
        logic                       last_result;
        logic [lkv_pkg::CNT_W-1:0]  occupancy;
        logic [lkv_pkg::STAT_W-1:0] gets;
        logic [lkv_pkg::STAT_W-1:0] hits;
        logic [lkv_pkg::STAT_W-1:0] misses;
        logic [lkv_pkg::STAT_W-1:0] puts;
        logic [lkv_pkg::STAT_W-1:0] evictions;
    } cache_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [lkv_pkg::CMD_W-1:0] command = '0;
    logic [lkv_pkg::KEY_W-1:0] lookup_key = '0;
    logic [lkv_pkg::VAL_W-1:0] store_value = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic found, is_eviction, last_result;
    logic [lkv_pkg::VAL_W-1:0] read_value;
    logic [lkv_pkg::KEY_W-1:0] evicted_key;
    logic [lkv_pkg::CNT_W-1:0] occupancy;
    logic [lkv_pkg::STAT_W-1:0] get_count, hit_count, miss_count, put_count, eviction_count;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [lkv_pkg::CNT_W-1:0] cfg_data = '0;

    // Predictor state
    logic [lkv_pkg::KEY_W-1:0] mdl_key [lkv_pkg::ENTRIES];
    logic [lkv_pkg::VAL_W-1:0] mdl_val [lkv_pkg::ENTRIES];
    logic                      mdl_vld [lkv_pkg::ENTRIES];
    int unsigned               mdl_rank [lkv_pkg::ENTRIES];
    int unsigned               mdl_total;
    logic [lkv_pkg::STAT_W-1:0] n_get, n_hit, n_miss, n_put, n_evict;
    logic [lkv_pkg::CNT_W-1:0] mdl_cap;

    cache_result_t expected_results[$];
    int errors = 0;
    bit idle_ok = 1'b1;   // random idling enabled
    bit hold_rx = 1'b0;   // long receiver hold-off

    lru_key_value_cache dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #2ms;
        $display("lru_key_value_cache_tb NOT OK");
        $finish;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        errors++;
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    endtask

    function automatic void model_reset();
        for (int i = 0; i < lkv_pkg::ENTRIES; i++)
        begin
            mdl_vld[i] = 1'b0;
            mdl_rank[i] = 0;
        end
        mdl_total = 0;
        n_get = '0; n_hit = '0; n_miss = '0; n_put = '0; n_evict = '0;
        mdl_cap = lkv_pkg::CNT_W'(lkv_pkg::ENTRIES);
    endfunction

    function automatic void push_result(logic f, logic [lkv_pkg::VAL_W-1:0] rv, logic ev,
                                        logic [lkv_pkg::KEY_W-1:0] ek, logic last);
        cache_result_t r;
        r.found = f; r.read_value = rv; r.is_eviction = ev; r.evicted_key = ek;
        r.last_result = last; r.occupancy = mdl_total[lkv_pkg::CNT_W-1:0];
        r.gets = n_get; r.hits = n_hit; r.misses = n_miss; r.puts = n_put;
        r.evictions = n_evict;
        expected_results.push_back(r);
    endfunction

    function automatic void touch_entry(int s);
        for (int i = 0; i < lkv_pkg::ENTRIES; i++)
            if (mdl_vld[i] && mdl_rank[i] < mdl_rank[s])
                mdl_rank[i]++;
        mdl_rank[s] = 0;
    endfunction

    function automatic void predict_command(logic [lkv_pkg::CMD_W-1:0] c,
                                            logic [lkv_pkg::KEY_W-1:0] k,
                                            logic [lkv_pkg::VAL_W-1:0] v);
        int slot = -1;
        int lr, cap, nev, r;
        logic f = 1'b0;
        logic [lkv_pkg::VAL_W-1:0] rv = '0;
        logic [lkv_pkg::KEY_W-1:0] gone [$];
        for (int i = 0; i < lkv_pkg::ENTRIES; i++)
            if (slot < 0 && mdl_vld[i] && mdl_key[i] == k)
                slot = i;
        case (c)
            lkv_pkg::CMD_GET:
            begin
                n_get++;
                if (slot >= 0)
                begin
                    f = 1'b1; rv = mdl_val[slot]; touch_entry(slot); n_hit++;
                end
                else
                    n_miss++;
            end
            lkv_pkg::CMD_PUT:
            begin
                n_put++;
                if (slot >= 0)
                begin
                    f = 1'b1; mdl_val[slot] = v; touch_entry(slot);
                end
                else
                begin
                    cap = int'(mdl_cap);
                    if (cap < 1) cap = 1;
                    if (cap > lkv_pkg::ENTRIES) cap = lkv_pkg::ENTRIES;
                    while (mdl_total + 1 > cap && gone.size() < lkv_pkg::ENTRIES)
                    begin
                        lr = -1;
                        for (int i = 0; i < lkv_pkg::ENTRIES; i++)
                            if (mdl_vld[i] && (lr < 0 || mdl_rank[i] > mdl_rank[lr]))
                                lr = i;
                        if (lr < 0) break;
                        gone.push_back(mdl_key[lr]);
                        mdl_vld[lr] = 1'b0;
                        mdl_total--;
                        n_evict++;
                    end
                    for (int i = 0; i < lkv_pkg::ENTRIES; i++)
                        if (mdl_vld[i]) mdl_rank[i]++;
                    for (int i = 0; i < lkv_pkg::ENTRIES; i++)
                        if (!mdl_vld[i])
                        begin
                            mdl_vld[i] = 1'b1; mdl_key[i] = k; mdl_val[i] = v;
                            mdl_rank[i] = 0; mdl_total++;
                            break;
                        end
                end
            end
            lkv_pkg::CMD_REMOVE:
                if (slot >= 0)
                begin
                    r = mdl_rank[slot];
                    f = 1'b1; mdl_vld[slot] = 1'b0; mdl_total--;
                    for (int i = 0; i < lkv_pkg::ENTRIES; i++)
                        if (mdl_vld[i] && mdl_rank[i] > r) mdl_rank[i]--;
                end
            lkv_pkg::CMD_CONTAINS: f = (slot >= 0);
            lkv_pkg::CMD_CLEAR:
            begin
                for (int i = 0; i < lkv_pkg::ENTRIES; i++) mdl_vld[i] = 1'b0;
                mdl_total = 0;
            end
            lkv_pkg::CMD_RSTSTAT:
            begin
                n_get = '0; n_hit = '0; n_miss = '0; n_put = '0; n_evict = '0;
            end
            default: ;
        endcase
        nev = gone.size();
        if (nev == 0)
            push_result(f, rv, 1'b0, '0, 1'b1);
        else
            for (int i = 0; i < nev; i++)
                push_result(f, '0, 1'b1, gone[i], i == nev - 1);
    endfunction

    // Send one item; returns at the edge that accepts it, valid left high.
    task automatic send_command(input logic [lkv_pkg::CMD_W-1:0] c,
                                input logic [lkv_pkg::KEY_W-1:0] k,
                                input logic [lkv_pkg::VAL_W-1:0] v);
        while (idle_ok && $urandom_range(99) < 38)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= c;
        lookup_key <= k;
        store_value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_command(c, k, v);
    endtask

    task automatic drain_block();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [lkv_pkg::CNT_W-1:0] cap);
        drain_block();
        cfg_valid <= 1'b1;
        cfg_data <= cap;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        mdl_cap = cap;
    endtask

    // Receiver stall
    always @(posedge clk)
        out_stall <= hold_rx || (idle_ok && $urandom_range(99) < 38);

    // Result checker
    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
        begin
            cache_result_t w;
            if (expected_results.size() == 0)
            begin
                report("unexpected result", 64'(out_valid), 64'd0);
            end
            else
            begin
                w = expected_results.pop_front();
                if (found !== w.found) report("found", 64'(found), 64'(w.found));
                if (read_value !== w.read_value)
                    report("read_value", 64'(read_value), 64'(w.read_value));
                if (is_eviction !== w.is_eviction)
                    report("is_eviction", 64'(is_eviction), 64'(w.is_eviction));
                if (evicted_key !== w.evicted_key)
                    report("evicted_key", 64'(evicted_key), 64'(w.evicted_key));
                if (last_result !== w.last_result)
                    report("last_result", 64'(last_result), 64'(w.last_result));
                if (occupancy !== w.occupancy)
                    report("occupancy", 64'(occupancy), 64'(w.occupancy));
                if (get_count !== w.gets)
                    report("get_count", 64'(get_count), 64'(w.gets));
                if (hit_count !== w.hits)
                    report("hit_count", 64'(hit_count), 64'(w.hits));
                if (miss_count !== w.misses)
                    report("miss_count", 64'(miss_count), 64'(w.misses));
                if (put_count !== w.puts)
                    report("put_count", 64'(put_count), 64'(w.puts));
                if (eviction_count !== w.evictions)
                    report("eviction_count", 64'(eviction_count), 64'(w.evictions));
            end
        end

    task automatic test_directed();
        send_command(lkv_pkg::CMD_GET, 32'h0, 32'h0);
        send_command(lkv_pkg::CMD_PUT, 32'h0, 32'hFFFF_FFFF);
        send_command(lkv_pkg::CMD_PUT, 32'hFFFF_FFFF, 32'h0);
        send_command(lkv_pkg::CMD_GET, 32'h0, 32'h0);
        send_command(lkv_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h1234_5678);
        send_command(lkv_pkg::CMD_PUT, 32'h0, 32'hA5A5_5A5A);
        send_command(lkv_pkg::CMD_CONTAINS, 32'hFFFF_FFFF, 32'h0);
        send_command(lkv_pkg::CMD_CONTAINS, 32'h5, 32'h0);
        send_command(lkv_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 32'h0);
        send_command(lkv_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 32'h0);
        send_command(CMD_SPARE6, 32'h0, 32'h1);
        send_command(CMD_SPARE7, 32'h0, 32'hFFFF_FFFF);
        send_command(lkv_pkg::CMD_RSTSTAT, 32'h0, 32'h0);
        send_command(lkv_pkg::CMD_CLEAR, 32'h0, 32'h0);
        send_command(lkv_pkg::CMD_GET, 32'h0, 32'h0);
    endtask

    // Fill, then shrink capacity so the next new put trims several entries
    task automatic test_shrink_trim();
        write_capacity(5'd16);
        for (int i = 0; i < 17; i++)
            send_command(lkv_pkg::CMD_PUT, 32'h100 + i, $urandom);
        write_capacity(5'd2);
        send_command(lkv_pkg::CMD_GET, 32'h10A, 32'h0);
        send_command(lkv_pkg::CMD_PUT, 32'h200, 32'h77);
        write_capacity(5'd0);
        send_command(lkv_pkg::CMD_PUT, 32'h201, 32'h78);
        send_command(lkv_pkg::CMD_PUT, 32'h201, 32'h79);
        write_capacity(5'd31);
        send_command(lkv_pkg::CMD_PUT, 32'h202, 32'h7A);
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_rx = 1'b1;
                repeat (200) @(posedge clk);
                hold_rx = 1'b0;
            end
            for (int i = 0; i < 12; i++)
                send_command(lkv_pkg::CMD_PUT, $urandom_range(15), $urandom);
        join
    endtask

    task automatic test_random(input int count, input logic [lkv_pkg::CNT_W-1:0] cap);
        logic [lkv_pkg::CMD_W-1:0] c;
        logic [lkv_pkg::KEY_W-1:0] k;
        int p;
        write_capacity(cap);
        for (int i = 0; i < count; i++)
        begin
            p = $urandom_range(99);
            c = p < 35 ? lkv_pkg::CMD_PUT : p < 65 ? lkv_pkg::CMD_GET :
                p < 78 ? lkv_pkg::CMD_REMOVE : p < 90 ? lkv_pkg::CMD_CONTAINS :
                p < 93 ? lkv_pkg::CMD_CLEAR : p < 96 ? lkv_pkg::CMD_RSTSTAT :
                3'($urandom_range(7));
            // mostly a small key pool so hits and evictions happen
            k = $urandom_range(9) < 8 ? 32'($urandom_range(23)) : $urandom;
            send_command(c, k, $urandom);
        end
    endtask

    initial
    begin
        model_reset();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_shrink_trim();
        test_backpressure();
        test_random(50, 5'd4);
        idle_ok = 1'b0;
        test_random(40, 5'd16);
        idle_ok = 1'b1;
        test_random(55, 5'd1);
        test_random(55, 5'd9);
        drain_block();
        if (errors == 0)
            $display("lru_key_value_cache_tb OK");
        else
            $display("lru_key_value_cache_tb NOT OK");
        $finish;
    end
endmodule
